// File: rtl/efpf_pkg.sv
// Shared types, constants and helper functions of the edge-flag pattern fill block.
`default_nettype none
package efpf_pkg;

  localparam int DefWidthPixels  = 512;
  localparam int DefHeightPixels = 512;
  localparam int DefMaxVertices  = 64;
  localparam int PatternRows     = 23;
  localparam int PatternCols     = 46;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_CLOSE = 2'd1;
  localparam logic [1:0] CMD_SCAN  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FEW      = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic [1:0] cmd;
    logic [8:0] vert_x;
    logic [8:0] vert_y;
    logic [8:0] scan_row;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [8:0]  row;
    logic [3:0]  word_index;
    logic [31:0] paint_bits;
    logic [23:0] color;
    logic        last;
  } out_item_t;

  localparam logic [45:0] PatFull =
      ((46'd1 << 11) - (46'd1 << 2)) | ((46'd1 << 22) - (46'd1 << 13)) |
      ((46'd1 << 33) - (46'd1 << 24)) | ((46'd1 << 44) - (46'd1 << 35));
  localparam logic [45:0] PatUpper =
      (46'd1 << 2) | (46'd1 << 10) | (46'd1 << 13) | (46'd1 << 21) |
      (46'd1 << 32) | (46'd1 << 43);
  localparam logic [45:0] PatMid =
      (46'd1 << 2) | (46'd1 << 10) | ((46'd1 << 22) - (46'd1 << 13)) |
      ((46'd1 << 33) - (46'd1 << 24)) | ((46'd1 << 44) - (46'd1 << 35));
  localparam logic [45:0] PatLower =
      (46'd1 << 2) | (46'd1 << 10) | (46'd1 << 21) | (46'd1 << 24) |
      (46'd1 << 43);

  // One row of the fixed fill pattern; bit c is pattern column c.
  function automatic logic [45:0] pat_row(input logic [4:0] r);
    logic [45:0] p;
    case (r)
      5'd2, 5'd20: p = PatFull;
      5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10: p = PatUpper;
      5'd11: p = PatMid;
      5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19: p = PatLower;
      default: p = '0;
    endcase
    return p;
  endfunction

  // Row modulo the pattern height by five compare-and-subtract steps.
  function automatic logic [4:0] row_mod(input logic [8:0] v);
    logic [9:0] acc;
    logic [9:0] sub;
    acc = {1'b0, v};
    for (int k = 4; k >= 0; k--) begin
      sub = 10'(PatternRows << k);
      if (acc >= sub) begin
        acc = acc - sub;
      end
    end
    return acc[4:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/edge_flag_pattern_fill.sv
// Top level of the edge-flag polygon fill block with pattern mask.
//
//  Channel   | Signals                          | Direction
//  ----------+----------------------------------+----------
//  input     | in_valid_i, in_ready_o, in_item_i  | in
//  result    | out_valid_o, out_ready_i, out_item_o | out
//  config    | cfg_we_i, cfg_data_i (fill color) | in
//
// An add item is taken in the idle state. A close item sweeps the mask clean, one word per cycle,
// then checks the status, reads the last and first vertices, and per vertex reads the next
// vertex and does its bookkeeping plus, for a sloped edge, a pass through the restoring divider
// that forms the slope and a read and toggle write per row walked inside the mask.
// A row scan reads each word, then forms its parity/pattern bits in the emit state.
// The same sweep runs after reset; a stalled output holds the sequencer in its emit state.
`default_nettype none
module edge_flag_pattern_fill #(
  parameter int WIDTH_PIXELS  = efpf_pkg::DefWidthPixels,
  parameter int HEIGHT_PIXELS = efpf_pkg::DefHeightPixels,
  parameter int MAX_VERTICES  = efpf_pkg::DefMaxVertices
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire efpf_pkg::in_item_t  in_item_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      efpf_pkg::out_item_t out_item_o,
  input  wire logic               cfg_we_i,
  input  wire logic [23:0]        cfg_data_i
);

  localparam int WordsPerRow = WIDTH_PIXELS / 32;
  localparam int ScanWords   = (WordsPerRow > 16) ? 16 : WordsPerRow;
  localparam int Depth       = HEIGHT_PIXELS * WordsPerRow;
  localparam int AW          = $clog2(Depth);
  localparam int VA          = $clog2(MAX_VERTICES);
  localparam int VC          = $clog2(MAX_VERTICES + 1);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_CLR     = 5'd1;
  localparam logic [4:0] S_CL_CHK  = 5'd2;
  localparam logic [4:0] S_VP      = 5'd3;
  localparam logic [4:0] S_VP2     = 5'd4;
  localparam logic [4:0] S_VC      = 5'd5;
  localparam logic [4:0] S_VN      = 5'd6;
  localparam logic [4:0] S_VN2     = 5'd7;
  localparam logic [4:0] S_EDGE    = 5'd8;
  localparam logic [4:0] S_DIV     = 5'd9;
  localparam logic [4:0] S_WK_INIT = 5'd10;
  localparam logic [4:0] S_WK_RD   = 5'd11;
  localparam logic [4:0] S_WK_WR   = 5'd12;
  localparam logic [4:0] S_EXT     = 5'd13;
  localparam logic [4:0] S_EXT_WR  = 5'd14;
  localparam logic [4:0] S_CL_DONE = 5'd15;
  localparam logic [4:0] S_SC_RD   = 5'd16;
  localparam logic [4:0] S_SC_EM   = 5'd17;

  logic [4:0]  state_q, state_d;
  logic [AW:0] clr_q, clr_d;
  logic        close_pend_q, close_pend_d;
  logic [VC-1:0] vcnt_q, vcnt_d;
  logic        ovf_q, ovf_d;
  logic [VC-1:0] vi_q, vi_d;
  logic [1:0]  status_q, status_d;
  logic [23:0] color_q;

  // Vertex walk registers.
  logic [8:0]  py_q, py_d;
  logic [8:0]  cx_q, cx_d, cy_q, cy_d;
  logic [8:0]  nx_q, nx_d, ny_q, ny_d;
  logic [8:0]  ady_q, ady_d;
  logic        yneg_q, yneg_d;
  logic        xneg_q, xneg_d;
  logic [24:0] dvd_q, dvd_d;
  logic [8:0]  rem_q, rem_d;
  logic [4:0]  dcnt_q, dcnt_d;
  logic signed [27:0] xs_q, xs_d, step_q, step_d;
  logic [8:0]  wy_q, wy_d;
  logic [8:0]  wn_q, wn_d;
  logic [AW-1:0] maddr_q, maddr_d;
  logic [4:0]  mbit_q, mbit_d;

  // Scan registers.
  logic [8:0]  srow_q, srow_d;
  logic [45:0] prow_q, prow_d;
  logic [3:0]  sw_q, sw_d;
  logic [5:0]  phase_q, phase_d;
  logic        par_q, par_d;

  efpf_pkg::out_item_t out_q, out_d;
  logic        out_valid_q, out_valid_d;

  // Memories.
  logic [31:0] mask_mem [Depth];
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0] mem_wdata, mem_rdata_q;

  logic [17:0] vstore [MAX_VERTICES];
  logic        v_we, v_re;
  logic [VA-1:0] v_waddr, v_raddr;
  logic [17:0] v_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mask_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mask_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (v_we) begin
      vstore[v_waddr] <= {in_item_i.vert_y, in_item_i.vert_x};
    end
    if (v_re) begin
      v_rdata_q <= vstore[v_raddr];
    end
  end

  function automatic logic [AW-1:0] maddr(input logic [8:0] r, input logic [6:0] w);
    return AW'(int'(r) * WordsPerRow + int'(w));
  endfunction

  logic        out_free;
  logic signed [27:0] t_w;
  logic [10:0] col_w;
  logic [9:0]  trial_w;
  logic [9:0]  dy_w;
  logic [8:0]  dx_mag_w;
  logic        extreme_w;
  logic [31:0] flags_w, bits_w;
  logic [6:0]  pidx_w;
  logic [6:0]  pnext_w;
  logic [VC-1:0] vnext_w;

  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    t_w = xs_q + 28'sd32768;
    col_w = t_w[27] ? 11'd0 : t_w[26:16];
    trial_w = {rem_q, dvd_q[24]};
    dy_w = {1'b0, ny_q} - {1'b0, cy_q};
    dx_mag_w = (nx_q >= cx_q) ? (nx_q - cx_q) : (cx_q - nx_q);
    extreme_w = ((cy_q <= py_q) && (cy_q <= ny_q)) || ((cy_q >= py_q) && (cy_q >= ny_q));
    vnext_w = (vi_q + VC'(1) == vcnt_q) ? '0 : vi_q + VC'(1);
    flags_w = (int'(srow_q) < HEIGHT_PIXELS) ? mem_rdata_q : 32'd0;
    for (int k = 0; k < 32; k++) begin
      pidx_w = {1'b0, phase_q} + 7'(k);
      if (pidx_w >= 7'd46) begin
        pidx_w = pidx_w - 7'd46;
      end
      bits_w[k] = (par_q ^ (^(flags_w & (32'hFFFF_FFFF >> (31 - k))))) &
                  prow_q[pidx_w[5:0]];
    end
    pnext_w = {1'b0, phase_q} + 7'd32;
    if (pnext_w >= 7'd46) begin
      pnext_w = pnext_w - 7'd46;
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    close_pend_d = close_pend_q;
    vcnt_d = vcnt_q;
    ovf_d = ovf_q;
    vi_d = vi_q;
    status_d = status_q;
    py_d = py_q; cx_d = cx_q; cy_d = cy_q; nx_d = nx_q; ny_d = ny_q;
    ady_d = ady_q; yneg_d = yneg_q; xneg_d = xneg_q;
    dvd_d = dvd_q; rem_d = rem_q; dcnt_d = dcnt_q;
    xs_d = xs_q; step_d = step_q; wy_d = wy_q; wn_d = wn_q;
    maddr_d = maddr_q; mbit_d = mbit_q;
    srow_d = srow_q; prow_d = prow_q; sw_d = sw_q; phase_d = phase_q; par_d = par_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we = 1'b0; mem_re = 1'b0;
    mem_waddr = maddr_q; mem_raddr = maddr_q; mem_wdata = '0;
    v_we = 1'b0; v_re = 1'b0;
    v_waddr = vcnt_q[VA-1:0]; v_raddr = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_item_i.cmd)
            efpf_pkg::CMD_ADD: begin
              if (int'(vcnt_q) < MAX_VERTICES) begin
                v_we = 1'b1;
                vcnt_d = vcnt_q + VC'(1);
              end else begin
                ovf_d = 1'b1;
              end
            end
            efpf_pkg::CMD_CLOSE: begin
              clr_d = '0;
              close_pend_d = 1'b1;
              state_d = S_CLR;
            end
            efpf_pkg::CMD_SCAN: begin
              srow_d = in_item_i.scan_row;
              prow_d = efpf_pkg::pat_row(efpf_pkg::row_mod(in_item_i.scan_row));
              sw_d = '0;
              phase_d = '0;
              par_d = 1'b0;
              state_d = S_SC_RD;
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        mem_we = 1'b1;
        mem_waddr = clr_q[AW-1:0];
        mem_wdata = '0;
        clr_d = clr_q + (AW+1)'(1);
        if (int'(clr_q) == Depth - 1) begin
          state_d = close_pend_q ? S_CL_CHK : S_IDLE;
          close_pend_d = 1'b0;
        end
      end
      S_CL_CHK: begin
        if (ovf_q) begin
          status_d = efpf_pkg::ST_OVERFLOW;
          state_d = S_CL_DONE;
        end else if (vcnt_q < VC'(3)) begin
          status_d = efpf_pkg::ST_FEW;
          state_d = S_CL_DONE;
        end else begin
          status_d = efpf_pkg::ST_OK;
          state_d = S_VP;
        end
      end
      S_VP: begin
        v_re = 1'b1;
        v_raddr = VA'(vcnt_q - VC'(1));
        state_d = S_VP2;
      end
      S_VP2: begin
        py_d = v_rdata_q[17:9];
        v_re = 1'b1;
        v_raddr = '0;
        vi_d = '0;
        state_d = S_VC;
      end
      S_VC: begin
        cx_d = v_rdata_q[8:0];
        cy_d = v_rdata_q[17:9];
        state_d = S_VN;
      end
      S_VN: begin
        v_re = 1'b1;
        v_raddr = vnext_w[VA-1:0];
        state_d = S_VN2;
      end
      S_VN2: begin
        nx_d = v_rdata_q[8:0];
        ny_d = v_rdata_q[17:9];
        state_d = S_EDGE;
      end
      S_EDGE: begin
        if (dy_w == 10'd0) begin
          state_d = S_EXT;
        end else begin
          yneg_d = dy_w[9];
          ady_d = dy_w[9] ? 9'(-dy_w) : dy_w[8:0];
          xneg_d = (nx_q < cx_q);
          dvd_d = {dx_mag_w, 16'd0};
          rem_d = '0;
          dcnt_d = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (trial_w >= {1'b0, ady_q}) begin
          rem_d = 9'(trial_w - {1'b0, ady_q});
          dvd_d = {dvd_q[23:0], 1'b1};
        end else begin
          rem_d = trial_w[8:0];
          dvd_d = {dvd_q[23:0], 1'b0};
        end
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd24) begin
          state_d = S_WK_INIT;
        end
      end
      S_WK_INIT: begin
        step_d = xneg_q ? -$signed({3'b000, dvd_q}) : $signed({3'b000, dvd_q});
        xs_d = $signed({3'b000, cx_q, 16'd0});
        wy_d = cy_q;
        wn_d = ady_q;
        state_d = S_WK_RD;
      end
      S_WK_RD: begin
        if (int'(wy_q) < HEIGHT_PIXELS && int'(col_w) < WIDTH_PIXELS) begin
          maddr_d = maddr(wy_q, col_w[10:5] == 6'd0 ? 7'd0 : {1'b0, col_w[10:5]});
          mem_re = 1'b1;
          mem_raddr = maddr(wy_q, {1'b0, col_w[10:5]});
          maddr_d = mem_raddr;
          mbit_d = col_w[4:0];
          state_d = S_WK_WR;
        end else begin
          xs_d = xs_q + step_q;
          wy_d = yneg_q ? wy_q - 9'd1 : wy_q + 9'd1;
          wn_d = wn_q - 9'd1;
          state_d = (wn_q == 9'd1) ? S_EXT : S_WK_RD;
        end
      end
      S_WK_WR: begin
        mem_we = 1'b1;
        mem_wdata = mem_rdata_q ^ (32'd1 << mbit_q);
        xs_d = xs_q + step_q;
        wy_d = yneg_q ? wy_q - 9'd1 : wy_q + 9'd1;
        wn_d = wn_q - 9'd1;
        state_d = (wn_q == 9'd1) ? S_EXT : S_WK_RD;
      end
      S_EXT: begin
        if (extreme_w && int'(cy_q) < HEIGHT_PIXELS && int'(cx_q) < WIDTH_PIXELS) begin
          mem_re = 1'b1;
          mem_raddr = maddr(cy_q, {3'b000, cx_q[8:5]});
          maddr_d = mem_raddr;
          mbit_d = cx_q[4:0];
          state_d = S_EXT_WR;
        end else begin
          py_d = cy_q; cx_d = nx_q; cy_d = ny_q;
          vi_d = vi_q + VC'(1);
          state_d = (vi_q + VC'(1) == vcnt_q) ? S_CL_DONE : S_VN;
        end
      end
      S_EXT_WR: begin
        mem_we = 1'b1;
        mem_wdata = mem_rdata_q & ~(32'd1 << mbit_q);
        py_d = cy_q; cx_d = nx_q; cy_d = ny_q;
        vi_d = vi_q + VC'(1);
        state_d = (vi_q + VC'(1) == vcnt_q) ? S_CL_DONE : S_VN;
      end
      S_CL_DONE: begin
        if (out_free) begin
          out_d = '0;
          out_d.status = status_q;
          out_d.last = 1'b1;
          out_valid_d = 1'b1;
          vcnt_d = '0;
          ovf_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      S_SC_RD: begin
        mem_re = (int'(srow_q) < HEIGHT_PIXELS);
        mem_raddr = maddr(srow_q, {3'b000, sw_q});
        state_d = S_SC_EM;
      end
      S_SC_EM: begin
        if (out_free) begin
          out_d.status = efpf_pkg::ST_OK;
          out_d.row = srow_q;
          out_d.word_index = sw_q;
          out_d.paint_bits = bits_w;
          out_d.color = color_q;
          out_d.last = (int'(sw_q) == ScanWords - 1);
          out_valid_d = 1'b1;
          par_d = par_q ^ (^flags_w);
          phase_d = pnext_w[5:0];
          sw_d = sw_q + 4'd1;
          state_d = (int'(sw_q) == ScanWords - 1) ? S_IDLE : S_SC_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      clr_q <= '0;
      close_pend_q <= 1'b0;
      vcnt_q <= '0;
      ovf_q <= 1'b0;
      out_valid_q <= 1'b0;
      color_q <= '0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      close_pend_q <= close_pend_d;
      vcnt_q <= vcnt_d;
      ovf_q <= ovf_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        color_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vi_q <= vi_d; status_q <= status_d;
    py_q <= py_d; cx_q <= cx_d; cy_q <= cy_d; nx_q <= nx_d; ny_q <= ny_d;
    ady_q <= ady_d; yneg_q <= yneg_d; xneg_q <= xneg_d;
    dvd_q <= dvd_d; rem_q <= rem_d; dcnt_q <= dcnt_d;
    xs_q <= xs_d; step_q <= step_d; wy_q <= wy_d; wn_q <= wn_d;
    maddr_q <= maddr_d; mbit_q <= mbit_d;
    srow_q <= srow_d; prow_q <= prow_d; sw_q <= sw_d; phase_q <= phase_d; par_q <= par_d;
    out_q <= out_d;
  end

`ifndef ASSERT_OFF
  a_mem_we_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
      mem_we |-> (state_q == S_CLR || state_q == S_WK_WR || state_q == S_EXT_WR))
    else $error("mask memory written outside a write state");
  a_vcnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
      int'(vcnt_q) <= MAX_VERTICES)
    else $error("vertex count beyond store depth");
  a_close_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_CL_DONE && out_free) |=> (vcnt_q == '0 && !ovf_q))
    else $error("close did not empty the vertex store");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && !out_ready_i) |=> $stable(out_q))
    else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

// File: tb/tb_edge_flag_pattern_fill.sv
// Self-checking testbench for the edge-flag polygon fill block with pattern mask.
`default_nettype none
module tb_edge_flag_pattern_fill;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WidthPx   = 512;
  localparam int HeightPx  = 512;
  localparam int MaxVerts  = 64;
  localparam int RowWords  = WidthPx / 32;
  localparam int ScanWords = (RowWords > 16) ? 16 : RowWords;
  // The mask sweep after reset and on every close clears one mask word per cycle.
  localparam int SweepCycles = HeightPx * RowWords;
  localparam longint CycleLimit = 3_000_000;
  // Command code that the block ignores.
  localparam logic [1:0] CmdUnused = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  efpf_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  efpf_pkg::out_item_t out_item_o;
  logic cfg_we_i = 1'b0;
  logic [23:0] cfg_data_i = '0;

  edge_flag_pattern_fill DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  // Two delays give a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Shadow copy of the block's state, updated as items are sent.
  logic [23:0] shadow_color;
  logic [17:0] shadow_verts[MaxVerts];
  int          shadow_count;
  bit          shadow_overflow;
  logic [31:0] shadow_mask[HeightPx * RowWords];

  efpf_pkg::out_item_t paint_queue[$];   // expected results, oldest first
  int  fail_count = 0;
  int  result_count = 0;
  int  close_count = 0;
  int  scan_count = 0;
  bit  idle_enable = 1'b1;     // random gaps on both sides when set
  longint cycle_count = 0;

  // Run guard: a stuck handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t timeout after %0d cycles", $time, cycle_count);
      $display("TB_ERROR");
      $finish;
    end
  end

  // One pattern row; bit c is pattern column c.
  function automatic logic [45:0] pattern_row(int r);
    logic [45:0] full, upper, mid, lower;
    full = 46'h0; upper = 46'h0; mid = 46'h0; lower = 46'h0;
    for (int c = 0; c < 46; c++) begin
      if ((c >= 2 && c <= 10) || (c >= 13 && c <= 21) || (c >= 24 && c <= 32) ||
          (c >= 35 && c <= 43)) begin
        full[c] = 1'b1;
      end
    end
    upper[2] = 1; upper[10] = 1; upper[13] = 1; upper[21] = 1; upper[32] = 1; upper[43] = 1;
    mid = full;
    for (int c = 3; c <= 9; c++) mid[c] = 1'b0;
    lower[2] = 1; lower[10] = 1; lower[21] = 1; lower[24] = 1; lower[43] = 1;
    if (r == 2 || r == 20) return full;
    if (r >= 3 && r <= 10) return upper;
    if (r == 11) return mid;
    if (r >= 12 && r <= 19) return lower;
    return 46'h0;
  endfunction

  function automatic void flag_flip(int r, int c, bit clear_only);
    if (r < 0 || r >= HeightPx || c < 0 || c >= WidthPx) return;
    if (clear_only) shadow_mask[r * RowWords + c / 32][c % 32] = 1'b0;
    else shadow_mask[r * RowWords + c / 32][c % 32] ^= 1'b1;
  endfunction

  // Walks one edge in Q.16, toggling the rounded column on every row but the last.
  function automatic void trace_edge(int x1, int y1, int x2, int y2);
    int dy, ady, dir, step, xs, y, t;
    dy = y2 - y1;
    if (dy == 0) return;
    ady = (dy < 0) ? -dy : dy;
    dir = (dy < 0) ? -1 : 1;
    step = ((x2 - x1) * 65536) / ady;   // SV int division truncates toward zero
    xs = x1 * 65536;
    y = y1;
    for (int n = 0; n < ady; n++) begin
      t = xs + 32768;
      flag_flip(y, (t < 0) ? 0 : (t >>> 16), 1'b0);
      xs += step;
      y += dir;
    end
  endfunction

  function automatic logic [1:0] close_outline();
    logic [1:0] st;
    int n, x1, y1, x2, y2, y0;
    n = shadow_count;
    foreach (shadow_mask[i]) shadow_mask[i] = '0;
    if (shadow_overflow) st = efpf_pkg::ST_OVERFLOW;
    else if (n < 3) st = efpf_pkg::ST_FEW;
    else begin
      st = efpf_pkg::ST_OK;
      for (int i = 0; i < n; i++) begin
        y0 = shadow_verts[(i + n - 1) % n][17:9];
        x1 = shadow_verts[i][8:0];
        y1 = shadow_verts[i][17:9];
        x2 = shadow_verts[(i + 1) % n][8:0];
        y2 = shadow_verts[(i + 1) % n][17:9];
        trace_edge(x1, y1, x2, y2);
        // A vertex that is a local extreme in y keeps no flag.
        if ((y1 <= y0 && y1 <= y2) || (y1 >= y0 && y1 >= y2)) flag_flip(y1, x1, 1'b1);
      end
    end
    shadow_count = 0;
    shadow_overflow = 0;
    return st;
  endfunction

  // Updates the shadow state for one item and queues what it should produce.
  function automatic void predict_item(efpf_pkg::in_item_t it);
    efpf_pkg::out_item_t o;
    logic [45:0] prow;
    logic [31:0] flags;
    bit in_span;
    int x;
    case (it.cmd)
      efpf_pkg::CMD_ADD: begin
        if (shadow_count < MaxVerts) begin
          shadow_verts[shadow_count] = {it.vert_y, it.vert_x};
          shadow_count++;
        end else shadow_overflow = 1'b1;
      end
      efpf_pkg::CMD_CLOSE: begin
        o = '0;
        o.status = close_outline();
        o.last = 1'b1;
        paint_queue.push_back(o);
      end
      efpf_pkg::CMD_SCAN: begin
        prow = pattern_row(it.scan_row % efpf_pkg::PatternRows);
        in_span = 1'b0;
        for (int w = 0; w < ScanWords; w++) begin
          flags = (it.scan_row < HeightPx) ? shadow_mask[it.scan_row * RowWords + w] : '0;
          o = '0;
          o.row = it.scan_row;
          o.word_index = w[3:0];
          o.color = shadow_color;
          o.last = (w + 1 == ScanWords);
          for (int k = 0; k < 32; k++) begin
            x = w * 32 + k;
            if (flags[k]) in_span = !in_span;
            if (in_span && prow[x % efpf_pkg::PatternCols]) o.paint_bits[k] = 1'b1;
          end
          paint_queue.push_back(o);
        end
      end
      default: ;  // unused command does nothing
    endcase
  endfunction

  // Sends one item, with an optional random gap first; predicts it on acceptance.
  // Valid drops only during a gap or a wait, so each falling edge sees one update.
  task automatic send_item(efpf_pkg::in_item_t it);
    if (idle_enable) begin
      while ($urandom_range(99) < 19) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_item_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(it);
    @(negedge clk_i);
  endtask

  // Result side: random stalls, then each accepted result is compared.
  always @(negedge clk_i) begin
    out_ready_i <= idle_enable ? ($urandom_range(99) >= 19) : 1'b1;
  end

  always @(posedge clk_i) begin
    efpf_pkg::out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      result_count++;
      if (paint_queue.size() == 0) begin
        $display("%0t unexpected result %p", $time, out_item_o);
        fail_count++;
      end else begin
        want = paint_queue.pop_front();
        if (out_item_o !== want) begin
          $display("%0t mismatch: expected %p actual %p", $time, want, out_item_o);
          fail_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (paint_queue.size() != 0) @(negedge clk_i);
  endtask

  // Writes the fill color only once every result is out and any sweep is done.
  task automatic write_color(logic [23:0] value);
    wait_drained();
    repeat (SweepCycles + 200) @(negedge clk_i);
    cfg_data_i <= value;
    cfg_we_i <= 1'b1;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    shadow_color = value;
  endtask

  function automatic efpf_pkg::in_item_t add_item(int x, int y);
    efpf_pkg::in_item_t it;
    it = '0;
    it.cmd = efpf_pkg::CMD_ADD;
    it.vert_x = x[8:0];
    it.vert_y = y[8:0];
    return it;
  endfunction

  function automatic efpf_pkg::in_item_t cmd_item(logic [1:0] cmd, int r);
    efpf_pkg::in_item_t it;
    it = '0;
    it.cmd = cmd;
    it.scan_row = r[8:0];
    return it;
  endfunction

  task automatic close_and_scan(int r0, int r1);
    send_item(cmd_item(efpf_pkg::CMD_CLOSE, 0));
    close_count++;
    for (int r = r0; r <= r1; r++) begin
      send_item(cmd_item(efpf_pkg::CMD_SCAN, r));
      scan_count++;
    end
  endtask

  // Directed: status codes, extreme coordinates, horizontal edges, unused cmd.
  task automatic test_directed();
    close_and_scan(0, 0);                        // close with no vertices
    send_item(add_item(5, 5));
    send_item(add_item(9, 9));
    close_and_scan(5, 5);                        // fewer than three vertices
    send_item(add_item(0, 0));
    send_item(add_item(511, 0));                 // horizontal top edge
    send_item(add_item(511, 511));
    send_item(add_item(0, 511));
    close_and_scan(0, 1);
    send_item(cmd_item(CmdUnused, 511));         // ignored command
    close_and_scan(511, 511);
    send_item(add_item(3, 200));
    send_item(add_item(400, 2));
    send_item(add_item(300, 509));
    close_and_scan(2, 3);
    scan_count++;
    send_item(cmd_item(efpf_pkg::CMD_SCAN, 200));
  endtask

  // Overflow: more adds than the store holds, then a close.
  task automatic test_overflow();
    for (int i = 0; i <= MaxVerts; i++) send_item(add_item($urandom_range(511), $urandom_range(511)));
    close_and_scan(100, 100);
  endtask

  // Random polygons with random scans of rows that the polygon covers, and now and then of any row.
  task automatic test_random_polygons(int n_polys);
    int nv, ylo, yhi, yv;
    for (int p = 0; p < n_polys; p++) begin
      nv = $urandom_range(3, 8);
      ylo = 511; yhi = 0;
      for (int i = 0; i < nv; i++) begin
        yv = $urandom_range(511);
        if (yv < ylo) ylo = yv;
        if (yv > yhi) yhi = yv;
        send_item(add_item($urandom_range(511), yv));
      end
      if ($urandom_range(9) == 0) send_item(cmd_item(CmdUnused, $urandom_range(511)));
      send_item(cmd_item(efpf_pkg::CMD_CLOSE, 0));
      close_count++;
      for (int s = 0; s < 2; s++) begin
        send_item(cmd_item(efpf_pkg::CMD_SCAN, $urandom_range(ylo, yhi)));
        scan_count++;
      end
      if ($urandom_range(4) == 0) begin
        send_item(cmd_item(efpf_pkg::CMD_SCAN, $urandom_range(511)));
        scan_count++;
      end
    end
  endtask

  // The sender holds off until every expected result has arrived.
  task automatic test_drain_pause();
    wait_drained();
    send_item(cmd_item(efpf_pkg::CMD_SCAN, 511));
    scan_count++;
  endtask

  initial begin
    shadow_color = '0;
    shadow_count = 0;
    shadow_overflow = 0;
    foreach (shadow_mask[i]) shadow_mask[i] = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    write_color(24'hFFFFFF);
    test_directed();
    test_overflow();
    write_color(24'h000000);
    test_random_polygons(1);
    test_drain_pause();
    write_color(24'hA5C35A);
    // A stretch with no idling on either side.
    idle_enable = 1'b0;
    test_random_polygons(1);
    idle_enable = 1'b1;
    write_color(24'($urandom_range(24'hFFFFFF)));
    test_random_polygons(1);

    wait_drained();
    repeat (200) @(negedge clk_i);
    $display("Covered %0d closes and %0d row scans, %0d result words checked.",
             close_count, scan_count, result_count);
    if (fail_count == 0 && paint_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
rtl/efpf_pkg.sv
rtl/edge_flag_pattern_fill.sv
tb/tb_edge_flag_pattern_fill.sv
